### hw/rtl/flow_table_lru_expiry_top_macros.svh
// assertion helpers for the flow table
`ifndef FLOW_TABLE_LRU_EXPIRY_TOP_MACROS_SVH
`define FLOW_TABLE_LRU_EXPIRY_TOP_MACROS_SVH
`define FT_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("flow table check failed");
`define FT_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("flow table check failed");
`endif

### hw/rtl/ftle_pkg.sv
package ftle_pkg;
    localparam int Capacity  = 256;
    localparam int SlotW     = 8;
    localparam int CountW    = 9;
    localparam int StampW    = 32;
    localparam int KeyW      = 96;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_EXPIRE = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port_num;
        logic [15:0] dst_port_num;
        logic [31:0] now_time;
    } t_in_item;

    typedef struct packed {
        logic        hit;
        logic        full_drop;
        logic [8:0]  removed_count;
        logic [8:0]  occupancy;
    } t_out_item;

    // controller -> datapath commands
    typedef struct packed {
        logic load;        // capture request
        logic scan_step;   // compare current scan slot
        logic scan_clr;    // restart scan
        logic rd_nbr;      // pick scan target: match, else first free slot
        logic do_unlink;   // unlink target
        logic do_append;   // append target at newest end
        logic do_alloc;    // write key into target and mark valid
        logic do_free;     // clear valid and decrement count
        logic do_stamp;    // write stamp of target
        logic set_oldest;  // target := oldest slot, read its stamp
        logic set_hit;
        logic set_drop;
        logic inc_removed;
    } t_ctl;

    // datapath -> controller status
    typedef struct packed {
        logic scan_last;
        logic tgt_found;
        logic have_free;
        logic is_newest;
        logic empty;
        logic full;
        logic aged;
    } t_sts;
endpackage

### hw/rtl/ftle_datapath.sv
module ftle_datapath (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  ftle_pkg::t_ctl           i_ctl,
    input  ftle_pkg::t_in_item       i_req,
    input  logic [31:0]              i_timeout,
    output ftle_pkg::t_sts           o_sts,
    output ftle_pkg::t_out_item      o_res
);
    logic [ftle_pkg::KeyW-1:0]   mem_key   [ftle_pkg::Capacity];
    logic [ftle_pkg::StampW-1:0] mem_stamp [ftle_pkg::Capacity];
    logic [ftle_pkg::SlotW-1:0]  mem_next  [ftle_pkg::Capacity];
    logic [ftle_pkg::SlotW-1:0]  mem_prev  [ftle_pkg::Capacity];
    logic [ftle_pkg::Capacity-1:0] r_valid;

    ftle_pkg::t_in_item          r_req;
    logic [ftle_pkg::SlotW-1:0]  r_scan;
    logic                        r_cmp_vld;
    logic [ftle_pkg::SlotW-1:0]  r_cmp_slot;
    logic [ftle_pkg::SlotW-1:0]  r_tgt;
    logic                        r_tgt_found;
    logic [ftle_pkg::SlotW-1:0]  r_free;
    logic                        r_free_found;
    logic [ftle_pkg::KeyW-1:0]   r_key_rd;
    logic [ftle_pkg::StampW-1:0] r_stamp_rd;
    logic [ftle_pkg::SlotW-1:0]  r_nxt_rd;
    logic [ftle_pkg::SlotW-1:0]  r_prv_rd;
    logic [ftle_pkg::SlotW-1:0]  r_oldest;
    logic [ftle_pkg::SlotW-1:0]  r_newest;
    logic [ftle_pkg::CountW-1:0] r_count;
    logic                        r_hit;
    logic                        r_drop;
    logic [ftle_pkg::CountW-1:0] r_removed;

    logic [ftle_pkg::KeyW-1:0]   w_key;
    logic [ftle_pkg::StampW-1:0] w_age;
    logic                        w_match;

    assign w_key = {r_req.src_addr, r_req.dst_addr, r_req.src_port_num, r_req.dst_port_num};
    assign w_age = r_req.now_time - r_stamp_rd;
    // key read is registered, so the compare comes in the cycle after its scan address
    assign w_match = r_cmp_vld && r_valid[r_cmp_slot] && (r_key_rd == w_key);

    always_ff @(posedge i_clk) begin
        r_key_rd   <= mem_key[r_scan];
        r_stamp_rd <= mem_stamp[r_tgt];
        r_nxt_rd   <= mem_next[r_tgt];
        r_prv_rd   <= mem_prev[r_tgt];
        if (i_ctl.do_alloc) begin
            mem_key[r_tgt] <= w_key;
        end
        if (i_ctl.do_stamp || i_ctl.do_alloc) begin
            mem_stamp[r_tgt] <= r_req.now_time;
        end
    end

    // link updates: unlink and append are issued in separate cycles
    always_ff @(posedge i_clk) begin
        if (i_ctl.do_unlink) begin
            if (r_tgt != r_oldest) begin
                mem_next[r_prv_rd] <= r_nxt_rd;
            end
        end else if (i_ctl.do_append && (r_count != '0)) begin
            mem_next[r_newest] <= r_tgt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.do_unlink) begin
            if (r_tgt != r_newest) begin
                mem_prev[r_nxt_rd] <= r_prv_rd;
            end
        end else if (i_ctl.do_append && (r_count != '0)) begin
            mem_prev[r_tgt] <= r_newest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_oldest  <= '0;
            r_newest  <= '0;
            r_count   <= '0;
            r_scan    <= '0;
            r_cmp_vld <= 1'b0;
            r_cmp_slot <= '0;
            r_tgt     <= '0;
            r_tgt_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_free    <= '0;
            r_hit     <= 1'b0;
            r_drop    <= 1'b0;
            r_removed <= '0;
        end else begin
            if (i_ctl.load) begin
                r_req     <= i_req;
                r_hit     <= 1'b0;
                r_drop    <= 1'b0;
                r_removed <= '0;
            end
            r_cmp_vld  <= i_ctl.scan_step;
            r_cmp_slot <= r_scan;
            if (i_ctl.scan_clr) begin
                r_scan       <= '0;
                r_tgt_found  <= 1'b0;
                r_free_found <= 1'b0;
            end else begin
                if (i_ctl.scan_step) begin
                    r_scan <= r_scan + 1'b1;
                end
                if (w_match) begin
                    r_tgt_found <= 1'b1;
                end
                if (i_ctl.scan_step && !r_valid[r_scan] && !r_free_found) begin
                    r_free       <= r_scan;
                    r_free_found <= 1'b1;
                end
            end
            if (i_ctl.set_hit) begin
                r_hit <= 1'b1;
            end
            if (i_ctl.set_drop) begin
                r_drop <= 1'b1;
            end
            if (i_ctl.inc_removed) begin
                r_removed <= r_removed + 1'b1;
            end
            // first match wins; with no match the first free slot becomes the target
            if (i_ctl.set_oldest) begin
                r_tgt <= r_oldest;
            end else if (w_match && !r_tgt_found) begin
                r_tgt <= r_cmp_slot;
            end else if (i_ctl.rd_nbr && !r_tgt_found) begin
                r_tgt <= r_free;
            end
            if (i_ctl.do_unlink) begin
                if (r_tgt == r_oldest) begin
                    r_oldest <= r_nxt_rd;
                end
                if (r_tgt == r_newest) begin
                    r_newest <= r_prv_rd;
                end
            end else if (i_ctl.do_append) begin
                if (r_count == '0) begin
                    r_oldest <= r_tgt;
                end
                r_newest <= r_tgt;
            end
            if (i_ctl.do_alloc) begin
                r_valid[r_tgt] <= 1'b1;
                r_count <= r_count + 1'b1;
            end else if (i_ctl.do_free) begin
                r_valid[r_tgt] <= 1'b0;
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_comb begin
        o_sts.scan_last  = (r_scan == ftle_pkg::SlotW'(ftle_pkg::Capacity - 1));
        o_sts.tgt_found  = r_tgt_found;
        o_sts.have_free  = r_free_found;
        o_sts.is_newest  = (r_tgt == r_newest);
        o_sts.empty      = (r_count == '0);
        o_sts.full       = (r_count == ftle_pkg::CountW'(ftle_pkg::Capacity));
        o_sts.aged       = (w_age > i_timeout);
        o_res.hit           = r_hit;
        o_res.full_drop     = r_drop;
        o_res.removed_count = r_removed;
        o_res.occupancy     = r_count;
    end
endmodule

### hw/rtl/ftle_ctrl.sv
module ftle_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [1:0]          i_cmd,
    input  ftle_pkg::t_sts      i_sts,
    input  logic                i_out_stall,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output ftle_pkg::t_ctl      o_ctl
);
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SCAN   = 4'd1;
    localparam logic [3:0] ST_DECIDE = 4'd2;
    localparam logic [3:0] ST_LINK   = 4'd3;
    localparam logic [3:0] ST_UNLINK = 4'd4;
    localparam logic [3:0] ST_APPEND = 4'd5;
    localparam logic [3:0] ST_EXP_RD = 4'd6;
    localparam logic [3:0] ST_EXP_CK = 4'd7;
    localparam logic [3:0] ST_EXP_LK = 4'd8;
    localparam logic [3:0] ST_EXP_UL = 4'd9;
    localparam logic [3:0] ST_DONE   = 4'd10;
    localparam logic [3:0] ST_SETTGT = 4'd11;

    logic [3:0] r_state, n_state;
    logic [1:0] r_cmd;
    logic       r_rem, n_rem;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = (r_state == ST_DONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cmd   <= ftle_pkg::CMD_INSERT;
            r_rem   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rem   <= n_rem;
            if (r_state == ST_IDLE && i_in_valid) begin
                r_cmd <= i_cmd;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_rem   = r_rem;
        o_ctl   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.load     = 1'b1;
                    o_ctl.scan_clr = 1'b1;
                    n_state = (i_cmd == ftle_pkg::CMD_EXPIRE) ? ST_EXP_RD : ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_ctl.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = ST_SETTGT;
                end
            end
            ST_SETTGT: begin
                // last slot is compared here
                o_ctl.rd_nbr = 1'b1;
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (i_sts.tgt_found) begin
                    o_ctl.set_hit = 1'b1;
                    if (r_cmd == ftle_pkg::CMD_REMOVE) begin
                        n_rem = 1'b1;
                        n_state = ST_LINK;
                    end else if (i_sts.is_newest) begin
                        o_ctl.do_stamp = 1'b1;
                        n_state = ST_DONE;
                    end else begin
                        n_rem = 1'b0;
                        n_state = ST_LINK;
                    end
                end else if (r_cmd == ftle_pkg::CMD_INSERT) begin
                    if (i_sts.full || !i_sts.have_free) begin
                        o_ctl.set_drop = 1'b1;
                        n_state = ST_DONE;
                    end else begin
                        o_ctl.do_append = 1'b1;
                        o_ctl.do_alloc  = 1'b1;
                        n_state = ST_DONE;
                    end
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_LINK: begin
                // link words of the target are read this cycle
                n_state = ST_UNLINK;
            end
            ST_UNLINK: begin
                o_ctl.do_unlink = 1'b1;
                if (r_rem) begin
                    o_ctl.do_free     = 1'b1;
                    o_ctl.inc_removed = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_APPEND;
                end
            end
            ST_APPEND: begin
                o_ctl.do_append = 1'b1;
                o_ctl.do_stamp  = 1'b1;
                n_state = ST_DONE;
            end
            ST_EXP_RD: begin
                if (i_sts.empty) begin
                    n_state = ST_DONE;
                end else begin
                    o_ctl.set_oldest = 1'b1;
                    n_state = ST_EXP_CK;
                end
            end
            ST_EXP_CK: begin
                // stamp of oldest is being read this cycle
                n_state = ST_EXP_LK;
            end
            ST_EXP_LK: begin
                if (i_sts.aged) begin
                    n_state = ST_EXP_UL;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_EXP_UL: begin
                o_ctl.do_unlink   = 1'b1;
                o_ctl.do_free     = 1'b1;
                o_ctl.inc_removed = 1'b1;
                n_state = ST_EXP_RD;
            end
            ST_DONE: begin
                if (!i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

### hw/rtl/flow_table_lru_expiry_top.sv
// insert/lookup/remove: a key scan over all slots, a compare of the last slot,
// a decide step, then relinking of a hit entry where needed (link, unlink, append)
// expire: on a nonempty table, read the oldest entry, check its age and remove it,
// until the table empties or a fresh entry is seen; one request in flight at a time
// the next request is accepted once the result is taken and the block is idle again
// reset clears valid bits, list ends and count, and sets the timeout to 1000000
`include "flow_table_lru_expiry_top_macros.svh"
module flow_table_lru_expiry_top (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  ftle_pkg::t_in_item       i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output ftle_pkg::t_out_item      o_out_data,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [31:0]              i_cfg_data
);
    logic [31:0]    r_timeout;
    ftle_pkg::t_ctl w_ctl;
    ftle_pkg::t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= 32'd1000000;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_timeout <= i_cfg_data;
        end
    end

    ftle_datapath u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_req     (i_in_data),
        .i_timeout (r_timeout),
        .o_sts     (w_sts),
        .o_res     (o_out_data)
    );

    ftle_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cmd       (i_in_data.cmd),
        .i_sts       (w_sts),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_ctl       (w_ctl)
    );

    `FT_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, o_out_valid, o_in_stall)
    `FT_ASSERT_IMP(a_occ_range, i_clk, i_rst_n, o_out_valid, o_out_data.occupancy <= 9'd256)
    `FT_ASSERT_IMP(a_drop_excl, i_clk, i_rst_n, o_out_valid, !(o_out_data.hit && o_out_data.full_drop))
endmodule
